[rtl/shl_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// shl_pkg
// Types and constants for the sorted hit list localizer.
// ----------------------------------------------------------------------------
package shl_pkg;

  localparam int CURVES  = 4;
  localparam int POINTS  = 32;
  localparam int CRV_W   = 2;
  localparam int PNT_W   = 5;
  localparam int IDX_W   = 6;
  localparam int MEM_D   = CURVES * POINTS;
  localparam int ADDR_W  = CRV_W + PNT_W;

  localparam logic [2:0] OP_CLEAR  = 3'd0;
  localparam logic [2:0] OP_INSERT = 3'd1;
  localparam logic [2:0] OP_AFTV   = 3'd2;
  localparam logic [2:0] OP_BEFV   = 3'd3;
  localparam logic [2:0] OP_AFTI   = 3'd4;
  localparam logic [2:0] OP_READ   = 3'd5;

  localparam logic [1:0] ORI_EXT   = 2'd2;

  localparam logic [1:0] ERR_OK    = 2'd0;
  localparam logic [1:0] ERR_FULL  = 2'd1;
  localparam logic [1:0] ERR_RANGE = 2'd2;

  typedef struct packed {
    logic signed [31:0] par;
    logic [1:0]         ori;
    logic [15:0]        face;
  } hit_t;

endpackage
`default_nettype wire

[rtl/sorted_hit_list_localizer_top.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// sorted_hit_list_localizer_top
// Per-curve sorted hit lists in one synchronous memory, with clear, insert,
// cluster localize queries and entry reads.
// ----------------------------------------------------------------------------
// channel  dir  handshake            word
// in       in   in_valid/in_ready    op, curve, param, transition, face_id,
//                                    entry_index
// out      out  out_valid/out_ready  found, orientation, range_first/last,
//                                    count, param_out, face_out, error
// cfg      in   cfg_valid/cfg_ready  tolerance
//
// One item at a time. Every list entry visited takes a memory read, then an
// evaluate step. The result register frees the input once loaded.
// Synchronous reset clears list lengths, tolerance and control; the hit
// memory is not cleared (entries beyond a list's length are never read).
// ----------------------------------------------------------------------------
module sorted_hit_list_localizer_top (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire logic [2:0]          in_op,
  input  wire logic [1:0]          in_curve,
  input  wire logic signed [31:0]  in_param,
  input  wire logic [1:0]          in_transition,
  input  wire logic [15:0]         in_face_id,
  input  wire logic [5:0]          in_entry_index,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output logic                     out_found,
  output logic [1:0]               out_orientation,
  output logic [5:0]               out_range_first,
  output logic [5:0]               out_range_last,
  output logic [5:0]               out_count,
  output logic signed [31:0]       out_param_out,
  output logic [15:0]              out_face_out,
  output logic [1:0]               out_error,
  input  wire logic                cfg_valid,
  output logic                     cfg_ready,
  input  wire logic [30:0]         cfg_tolerance
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_RD   = 3'd1;
  localparam logic [2:0] S_EV   = 3'd2;
  localparam logic [2:0] S_INSW = 3'd3;
  localparam logic [2:0] S_OUT  = 3'd4;

  localparam logic [1:0] PH_INS = 2'd0;
  localparam logic [1:0] PH_SRC = 2'd1;
  localparam logic [1:0] PH_SCN = 2'd2;
  localparam logic [1:0] PH_ENT = 2'd3;

  localparam logic [5:0] FULL_N = 6'(shl_pkg::POINTS);

  shl_pkg::hit_t mem [shl_pkg::MEM_D];
  shl_pkg::hit_t rdata_r;
  logic                        mem_re, mem_we;
  logic [shl_pkg::ADDR_W-1:0]  mem_ra, mem_wa;
  shl_pkg::hit_t               mem_wd;

  logic [2:0]  state_r, state_nxt;
  logic [1:0]  ph_r, ph_nxt;
  logic [2:0]  op_r, op_nxt;
  logic [1:0]  curve_r, curve_nxt;
  logic signed [31:0] prm_r, prm_nxt;
  logic [1:0]  ori_new_r, ori_new_nxt;
  logic [15:0] face_r, face_nxt;
  logic [5:0]  n_r, n_nxt;
  logic [5:0]  i_r, i_nxt;
  logic [1:0]  o_r, o_nxt;
  logic signed [31:0] p_r, p_nxt;
  logic        act_r, act_nxt;
  logic [30:0] tol_r, tol_nxt;
  logic [5:0]  len_r [shl_pkg::CURVES];
  logic [5:0]  len_nxt [shl_pkg::CURVES];

  logic        rf_r, rf_nxt;
  logic [1:0]  ror_r, ror_nxt;
  logic [5:0]  rfirst_r, rfirst_nxt;
  logic [5:0]  rlast_r, rlast_nxt;
  logic [5:0]  rcnt_r, rcnt_nxt;
  logic signed [31:0] rpar_r, rpar_nxt;
  logic [15:0] rface_r, rface_nxt;
  logic [1:0]  rerr_r, rerr_nxt;

  logic        ov_r, ov_nxt;
  logic        o_found_r;
  logic [1:0]  o_ori_r;
  logic [5:0]  o_first_r, o_last_r, o_cnt_r;
  logic signed [31:0] o_par_r;
  logic [15:0] o_face_r;
  logic [1:0]  o_err_r;
  logic        load;

  assign in_ready  = (state_r == S_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid = ov_r;
  assign out_found = o_found_r;
  assign out_orientation = o_ori_r;
  assign out_range_first = o_first_r;
  assign out_range_last  = o_last_r;
  assign out_count       = o_cnt_r;
  assign out_param_out   = o_par_r;
  assign out_face_out    = o_face_r;
  assign out_error       = o_err_r;

  assign load = (state_r == S_OUT) && (!ov_r || out_ready);

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (mem_re) begin
      rdata_r <= mem[mem_ra];
    end
  end

  always_comb begin
    logic signed [33:0] d34, p34, q34, t34, diff;
    logic [5:0]  nx, stop;
    logic [1:0]  om;
    logic        more, fin;
    shl_pkg::hit_t nh;
    state_nxt = state_r;  ph_nxt = ph_r;  op_nxt = op_r;  curve_nxt = curve_r;
    prm_nxt = prm_r;  ori_new_nxt = ori_new_r;  face_nxt = face_r;
    n_nxt = n_r;  i_nxt = i_r;  o_nxt = o_r;  p_nxt = p_r;  act_nxt = act_r;
    tol_nxt = cfg_valid ? cfg_tolerance : tol_r;
    len_nxt = len_r;
    rf_nxt = rf_r;  ror_nxt = ror_r;  rfirst_nxt = rfirst_r;  rlast_nxt = rlast_r;
    rcnt_nxt = rcnt_r;  rpar_nxt = rpar_r;  rface_nxt = rface_r;  rerr_nxt = rerr_r;
    mem_re = 1'b0;  mem_we = 1'b0;
    mem_ra = {curve_r, 5'(i_r - 6'd1)};
    mem_wa = {curve_r, i_r[shl_pkg::PNT_W-1:0]};
    nh.par = prm_r;  nh.ori = ori_new_r;  nh.face = face_r;
    mem_wd = nh;
    d34 = 34'(rdata_r.par);
    p34 = 34'(p_r);
    q34 = 34'(prm_r);
    t34 = $signed({3'b000, tol_r});
    diff = (op_r == shl_pkg::OP_BEFV) ? (p34 - d34) : (d34 - p34);
    nx = 6'd0;  stop = 6'd0;  om = o_r;  more = 1'b0;  fin = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          op_nxt = in_op;  curve_nxt = in_curve;  prm_nxt = in_param;
          ori_new_nxt = (in_transition > ORI_EXT_C()) ? shl_pkg::ORI_EXT : in_transition;
          face_nxt = in_face_id;
          n_nxt = len_r[in_curve];
          rf_nxt = 1'b0;  ror_nxt = 2'd0;  rfirst_nxt = 6'd0;  rlast_nxt = 6'd0;
          rcnt_nxt = len_r[in_curve];  rpar_nxt = '0;  rface_nxt = '0;
          rerr_nxt = shl_pkg::ERR_OK;  act_nxt = 1'b0;
          state_nxt = S_OUT;
          case (in_op)
            shl_pkg::OP_CLEAR: begin
              for (int c = 0; c < shl_pkg::CURVES; c++) len_nxt[c] = 6'd0;
              rcnt_nxt = 6'd0;
            end
            shl_pkg::OP_INSERT: begin
              if (len_r[in_curve] >= FULL_N) begin
                rerr_nxt = shl_pkg::ERR_FULL;
              end else begin
                ph_nxt = PH_INS;
                i_nxt = len_r[in_curve];
                state_nxt = (len_r[in_curve] == 6'd0) ? S_INSW : S_RD;
              end
            end
            shl_pkg::OP_AFTV, shl_pkg::OP_BEFV: begin
              ror_nxt = shl_pkg::ORI_EXT;
              ph_nxt = PH_SRC;
              i_nxt = (in_op == shl_pkg::OP_AFTV) ? 6'd1 : len_r[in_curve];
              if (len_r[in_curve] != 6'd0) state_nxt = S_RD;
            end
            shl_pkg::OP_AFTI: begin
              ror_nxt = shl_pkg::ORI_EXT;
              if (in_entry_index > len_r[in_curve]) rerr_nxt = shl_pkg::ERR_RANGE;
              if (in_entry_index < len_r[in_curve]) begin
                ph_nxt = PH_SCN;
                i_nxt = in_entry_index + 6'd1;
                rfirst_nxt = in_entry_index + 6'd1;
                state_nxt = S_RD;
              end
            end
            shl_pkg::OP_READ: begin
              if (in_entry_index == 6'd0 || in_entry_index > len_r[in_curve]) begin
                rerr_nxt = shl_pkg::ERR_RANGE;
              end else begin
                ph_nxt = PH_ENT;
                i_nxt = in_entry_index;
                state_nxt = S_RD;
              end
            end
            default: ;
          endcase
        end
      end
      S_RD: begin
        mem_re = 1'b1;
        state_nxt = S_EV;
      end
      S_EV: begin
        state_nxt = S_RD;
        case (ph_r)
          PH_INS: begin
            mem_we = 1'b1;
            if (rdata_r.par > prm_r) begin
              mem_wd = rdata_r;
              i_nxt = i_r - 6'd1;
              if (i_r == 6'd1) state_nxt = S_INSW;
            end else begin
              len_nxt[curve_r] = n_r + 6'd1;
              rcnt_nxt = n_r + 6'd1;
              state_nxt = S_OUT;
            end
          end
          PH_SRC: begin
            if (op_r == shl_pkg::OP_AFTV) begin
              if (d34 >= q34 - t34) begin
                rfirst_nxt = i_r;  ph_nxt = PH_SCN;
              end else begin
                i_nxt = i_r + 6'd1;
                if (i_r == n_r) state_nxt = S_OUT;
              end
            end else begin
              if (d34 <= q34 + t34) begin
                rlast_nxt = i_r;  ph_nxt = PH_SCN;
              end else begin
                i_nxt = i_r - 6'd1;
                if (i_r == 6'd1) state_nxt = S_OUT;
              end
            end
          end
          PH_SCN: begin
            more = (op_r != shl_pkg::OP_BEFV);
            nx = more ? i_r + 6'd1 : i_r - 6'd1;
            stop = more ? n_r + 6'd1 : 6'd0;
            if (!act_r) begin
              om = rdata_r.ori;  p_nxt = rdata_r.par;  act_nxt = 1'b1;
              i_nxt = nx;  fin = (nx == stop);
            end else if (diff <= t34) begin
              if (o_r != shl_pkg::ORI_EXT && o_r != rdata_r.ori) om = shl_pkg::ORI_EXT;
              i_nxt = nx;  fin = (nx == stop);
            end else begin
              nx = i_r;  fin = 1'b1;
            end
            o_nxt = om;
            if (fin) begin
              ror_nxt = om;
              act_nxt = 1'b0;
              if (om == shl_pkg::ORI_EXT) begin
                if (more) rfirst_nxt = nx; else rlast_nxt = nx;
                if (nx == stop) state_nxt = S_OUT;
              end else begin
                rf_nxt = 1'b1;
                if (more) rlast_nxt = nx - 6'd1; else rfirst_nxt = nx + 6'd1;
                state_nxt = S_OUT;
              end
            end
          end
          default: begin
            ror_nxt = rdata_r.ori;  rpar_nxt = rdata_r.par;  rface_nxt = rdata_r.face;
            state_nxt = S_OUT;
          end
        endcase
      end
      S_INSW: begin
        mem_we = 1'b1;
        len_nxt[curve_r] = n_r + 6'd1;
        rcnt_nxt = n_r + 6'd1;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (load) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
    ov_nxt = load ? 1'b1 : (ov_r && !out_ready);
  end

  function automatic logic [1:0] ORI_EXT_C();
    return shl_pkg::ORI_EXT;
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ov_r    <= 1'b0;
      tol_r   <= '0;
      act_r   <= 1'b0;
      for (int c = 0; c < shl_pkg::CURVES; c++) len_r[c] <= 6'd0;
    end else begin
      state_r <= state_nxt;
      ov_r    <= ov_nxt;
      tol_r   <= tol_nxt;
      act_r   <= act_nxt;
      len_r   <= len_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ph_r <= ph_nxt;  op_r <= op_nxt;  curve_r <= curve_nxt;  prm_r <= prm_nxt;
    ori_new_r <= ori_new_nxt;  face_r <= face_nxt;  n_r <= n_nxt;  i_r <= i_nxt;
    o_r <= o_nxt;  p_r <= p_nxt;
    rf_r <= rf_nxt;  ror_r <= ror_nxt;  rfirst_r <= rfirst_nxt;  rlast_r <= rlast_nxt;
    rcnt_r <= rcnt_nxt;  rpar_r <= rpar_nxt;  rface_r <= rface_nxt;  rerr_r <= rerr_nxt;
    if (load) begin
      o_found_r <= rf_r;  o_ori_r <= ror_r;  o_first_r <= rfirst_r;
      o_last_r <= rlast_r;  o_cnt_r <= rcnt_r;  o_par_r <= rpar_r;
      o_face_r <= rface_r;  o_err_r <= rerr_r;
    end
  end

endmodule
`default_nettype wire
